/* sv/sdt_pkg.sv */
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared types, constants and helpers for the scan result de-duplication table.
// ----------------------------------------------------------------------------
package sdt_pkg;

	localparam int DEF_TABLE_DEPTH = 8;
	localparam int NAME_BYTES      = 16;
	localparam int NAME_W          = 8 * NAME_BYTES;
	localparam int LEN_W           = 5;
	localparam int ADDR_W          = 48;
	localparam int RSSI_W          = 8;

	// Input beat payload, last field in the lowest bits.
	typedef struct packed {
		logic [2:0]               pad;
		logic signed [RSSI_W-1:0] signal_strength;
		logic [ADDR_W-1:0]        device_address;
		logic [LEN_W-1:0]         name_len;
		logic [63:0]              name_low;
		logic [63:0]              name_high;
	} in_item_t;

	localparam int IN_TDATA_W = $bits(in_item_t);

	// Kind and flag bits of an input beat.
	typedef struct packed {
		logic is_scan_response;
		logic action;
	} in_user_t;

	localparam int IN_TUSER_W = $bits(in_user_t);

	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// One table entry; also the output beat payload.
	typedef struct packed {
		logic signed [RSSI_W-1:0] strength;
		logic [ADDR_W-1:0]        address;
		logic [63:0]              name_low;
		logic [63:0]              name_high;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Byte mask over {name_high, name_low} covering the leading name bytes.
	function automatic logic [NAME_W-1:0] name_mask(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0]  n;
		logic [NAME_W-1:0] m;
		n = (len > LEN_W'(NAME_BYTES)) ? LEN_W'(NAME_BYTES) : len;
		m = '0;
		for (int b = 0; b < NAME_BYTES; b++) begin
			m[NAME_W-1-8*b -: 8] = (LEN_W'(b) < n) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

/* sv/sdt_table_mem.sv */
// ----------------------------------------------------------------------------
// sdt_table_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdt_table_mem #(
	parameter int DEPTH = sdt_pkg::DEF_TABLE_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  sdt_pkg::entry_t     wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output sdt_pkg::entry_t     rdata
);
	import sdt_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/sdt_out_stage.sv */
// ----------------------------------------------------------------------------
// sdt_out_stage
// Output register for flushed entries; frees the table while a beat waits.
// ----------------------------------------------------------------------------
module sdt_out_stage (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  sdt_pkg::entry_t           load_entry,
	input  logic                      load_last,
	output logic                      can_load,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [sdt_pkg::ENTRY_W-1:0] m_axis_tdata,
	output logic                      m_axis_tlast
);
	import sdt_pkg::*;

	logic   valid_q;
	entry_t entry_q;
	logic   last_q;

	assign can_load = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			entry_q <= load_entry;
			last_q  <= load_last;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = entry_q;
	assign m_axis_tlast  = last_q;

endmodule

/* sv/scan_result_dedup_table.sv */
// ----------------------------------------------------------------------------
// scan_result_dedup_table
// Table of scanned devices keyed by name, with RSSI update and flush.
// ----------------------------------------------------------------------------
// Input beats carry either a device report or an end-of-scan flush
// (s_axis_tuser bit 0). A report that is not a scan response is compared
// against the stored entries on its leading name_len name bytes; a hit
// updates that entry's strength, a miss appends a new entry. While the table
// holds TABLE_DEPTH entries every report is dropped. Reports produce no
// output beats.
// A report occupies the block until a hit, or on a miss until the append after
// the last stored entry: the single read port of the entry memory scans one
// entry per cycle, with the compare in the cycle after the read.
// A flush emits the stored entries in order on the master side, each one by
// a memory read and then a load of the output register, with
// tlast on the final one, and leaves the table empty. An empty flush emits
// nothing. The output register parts the two sides, so the next input beat
// is taken while the final entry still waits; a stalled receiver holds the
// flush at the current entry.
// Reset empties the table at once through the fill count; the memory itself
// is not swept, as entries past the fill count are never read.
// ----------------------------------------------------------------------------
module scan_result_dedup_table #(
	parameter int TABLE_DEPTH = sdt_pkg::DEF_TABLE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// name_high, name_low, name_len, device_address, signal_strength, zero pad
	input  logic [sdt_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// action, is_scan_response
	input  logic [sdt_pkg::IN_TUSER_W-1:0] s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// entry_name_high, entry_name_low, entry_address, entry_strength
	output logic [sdt_pkg::ENTRY_W-1:0]   m_axis_tdata,
	output logic                          m_axis_tlast
);
	import sdt_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE    = 4'b0001,
		S_SCAN    = 4'b0010,
		S_FL_RD   = 4'b0100,
		S_FL_LOAD = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     idx_q;
	logic [NAME_W-1:0] req_mask_q;
	logic [NAME_W-1:0] req_name_q;
	logic [ADDR_W-1:0] req_addr_q;
	logic [RSSI_W-1:0] req_rssi_q;
	logic              cmp_vld_s1;
	logic              cmp_last_s1;
	logic [AW-1:0]     cmp_idx_s1;

	in_item_t          in_item;
	in_user_t          in_user;
	logic              in_acc;
	logic              table_full;
	logic [NAME_W-1:0] in_mask;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	entry_t            mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	entry_t            mem_rdata;

	logic              scan_re;
	logic              hit;
	logic              append;
	logic              fl_last;
	logic              out_load;
	logic              out_can_load;

	assign in_item       = in_item_t'(s_axis_tdata);
	assign in_user       = in_user_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == S_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign table_full    = (count_q == CW'(TABLE_DEPTH));
	assign in_mask       = name_mask(in_item.name_len);

	// Scan: the read runs one entry ahead of the compare.
	assign scan_re = (state_q == S_SCAN) && (idx_q != count_q);
	assign hit     = (state_q == S_SCAN) && cmp_vld_s1 &&
	                 (({mem_rdata.name_high, mem_rdata.name_low} & req_mask_q) == req_name_q);
	// A miss on the last entry, or an empty table, appends.
	assign append  = (state_q == S_SCAN) && !hit &&
	                 ((cmp_vld_s1 && cmp_last_s1) || (!cmp_vld_s1 && count_q == '0));

	assign fl_last  = ((idx_q + CW'(1)) == count_q);
	assign out_load = (state_q == S_FL_LOAD) && out_can_load;

	assign mem_re    = scan_re || (state_q == S_FL_RD);
	assign mem_raddr = idx_q[AW-1:0];
	assign mem_we    = hit || append;
	assign mem_waddr = hit ? cmp_idx_s1 : count_q[AW-1:0];

	always_comb begin
		if (hit) begin
			mem_wdata          = mem_rdata;
			mem_wdata.strength = req_rssi_q;
		end else begin
			mem_wdata.name_high = req_name_q[NAME_W-1 -: 64];
			mem_wdata.name_low  = req_name_q[63:0];
			mem_wdata.address   = req_addr_q;
			mem_wdata.strength  = req_rssi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					idx_q      <= '0;
					cmp_vld_s1 <= 1'b0;
					if (in_acc) begin
						if (in_user.action == ACT_FLUSH) begin
							if (count_q != '0) begin
								state_q <= S_FL_RD;
							end
						end else if (!in_user.is_scan_response && !table_full) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_vld_s1 <= scan_re && !(hit || append);
					if (scan_re) begin
						idx_q <= idx_q + CW'(1);
					end
					if (append) begin
						count_q <= count_q + CW'(1);
					end
					if (hit || append) begin
						state_q <= S_IDLE;
					end
				end
				S_FL_RD: begin
					state_q <= S_FL_LOAD;
				end
				S_FL_LOAD: begin
					if (out_can_load) begin
						if (fl_last) begin
							count_q <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_FL_RD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_mask_q <= in_mask;
			req_name_q <= {in_item.name_high, in_item.name_low} & in_mask;
			req_addr_q <= in_item.device_address;
			req_rssi_q <= in_item.signal_strength;
		end
		if (scan_re) begin
			cmp_idx_s1  <= idx_q[AW-1:0];
			cmp_last_s1 <= ((idx_q + CW'(1)) == count_q);
		end
	end

	sdt_table_mem #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	sdt_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.load_entry    (mem_rdata),
		.load_last     (fl_last),
		.can_load      (out_can_load),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_no_write_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_SCAN))
		else $error("table write outside a report scan");

	a_append_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		append |-> !table_full)
		else $error("append into a full table");

	a_flush_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && in_user.action == ACT_FLUSH && count_q != '0) |=> (state_q == S_FL_RD))
		else $error("flush of a non-empty table did not start");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && fl_last) |=> (count_q == '0))
		else $error("table not emptied after final flushed entry");

endmodule
